// ----- src/pwl_pkg.sv -----
// shared types and constants for the piecewise linear interpolator
// no dependencies; used by pwl_ctrl, pwl_datapath and the top level
package pwl_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned COUNT_W = 7;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic write_point;
      logic load_query;
      logic rd_en;
      logic load_low;
      logic prep;
      logic mul;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic seg_match;
      logic seg_zero_width;
   } status_type;

endpackage

// ----- src/piecewise_linear_interpolator.sv -----
// piecewise linear interpolator, top level; depends on pwl_pkg, pwl_ctrl, pwl_datapath
// a breakpoint write gives no result; a query reads the first breakpoint, loads it as the
// low end and scans segments with one breakpoint ram read each, then multiplies and runs
// the serial divider before the result; queries are taken one at a time
// a query that misses or hits a zero-width segment skips multiply and divide
// synchronous reset clears control state and sets point_count to 2; ram content is undefined
module piecewise_linear_interpolator #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [103:0]  req_tdata,  // point_index, point_x, point_y, query_x, zero pad
   input  logic          req_tuser,  // mode
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,  // value
   output logic [2:0]    rsp_tuser,  // in_range, zero_width, saturated
   input  logic          csr_tvalid,
   output logic          csr_tready,
   input  logic [7:0]    csr_tdata   // point_count, zero pad
);

   pwl_pkg::cmd_type                  cmd;
   pwl_pkg::status_type               status;
   logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr;
   logic                              in_range, zero_width, saturated;

   pwl_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_count  (csr_tdata[pwl_pkg::COUNT_W-1:0]),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   pwl_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .point_index (req_tdata[5:0]),
      .point_x     (req_tdata[37:6]),
      .point_y     (req_tdata[69:38]),
      .query_x     (req_tdata[101:70]),
      .status      (status),
      .value       (rsp_tdata),
      .in_range    (in_range),
      .zero_width  (zero_width),
      .saturated   (saturated)
   );

   assign rsp_tuser = {saturated, zero_width, in_range};

endmodule

// ----- src/pwl_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module pwl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/pwl_datapath.sv -----
// datapath: breakpoint ram, segment compare, multiply, serial divide and result register
// depends on pwl_pkg and pwl_ram
module pwl_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                              clock,
   input  pwl_pkg::cmd_type                  cmd,
   input  logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
   input  logic [pwl_pkg::INDEX_W-1:0]       point_index,
   input  logic [pwl_pkg::COORD_W-1:0]       point_x,
   input  logic [pwl_pkg::COORD_W-1:0]       point_y,
   input  logic [pwl_pkg::COORD_W-1:0]       query_x,
   output pwl_pkg::status_type               status,
   output logic [pwl_pkg::COORD_W-1:0]       value,
   output logic                              in_range,
   output logic                              zero_width,
   output logic                              saturated
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int W  = pwl_pkg::COORD_W;

   logic          wr_en;
   logic [2*W-1:0] ram_data;
   logic [W-1:0]  hi_x, hi_y;

   logic [W-1:0]   q_ff, lo_x_ff, lo_y_ff, dx_ff, t_ff, mag_ff;
   logic           neg_ff, found_ff, zw_ff;
   logic [2*W-1:0] div_ff;
   logic [W-1:0]   value_ff;
   logic           in_range_ff, zero_width_ff, saturated_ff;

   logic [W:0]     dy;
   logic [W:0]     trial;
   logic           take;
   logic [W+1:0]   y0_ext, quo_ext, sum;
   logic           sum_sat;
   logic [W-1:0]   sum_value;

   assign wr_en = cmd.write_point && (32'(point_index) < 32'(TABLE_DEPTH));

   pwl_ram #(
      .WIDTH (2*W),
      .DEPTH (TABLE_DEPTH)
   ) u_points (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(point_index)),
      .wr_data ({point_y, point_x}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   assign hi_x = ram_data[W-1:0];
   assign hi_y = ram_data[2*W-1:W];

   assign status.seg_match      = ($signed(q_ff) >= $signed(lo_x_ff)) &&
                                  ($signed(q_ff) <= $signed(hi_x));
   assign status.seg_zero_width = (lo_x_ff == hi_x);

   assign dy = {hi_y[W-1], hi_y} - {lo_y_ff[W-1], lo_y_ff};

   // restoring division step, remainder in the upper half
   assign trial = {div_ff[2*W-1:W], div_ff[W-1]};
   assign take  = (trial >= {1'b0, dx_ff});

   assign y0_ext  = {{2{lo_y_ff[W-1]}}, lo_y_ff};
   assign quo_ext = {2'b00, div_ff[W-1:0]};
   assign sum     = neg_ff ? (y0_ext - quo_ext) : (y0_ext + quo_ext);
   assign sum_sat = !((sum[W+1] == sum[W]) && (sum[W] == sum[W-1]));
   assign sum_value = sum_sat ? (sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                              : sum[W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         q_ff     <= query_x;
         found_ff <= 1'b0;
         zw_ff    <= 1'b0;
      end
      if (cmd.load_low) begin
         lo_x_ff <= hi_x;
         lo_y_ff <= hi_y;
      end
      if (cmd.prep) begin
         found_ff <= 1'b1;
         zw_ff    <= status.seg_zero_width;
         dx_ff    <= hi_x - lo_x_ff;
         t_ff     <= q_ff - lo_x_ff;
         neg_ff   <= dy[W];
         mag_ff   <= dy[W] ? W'(-dy) : dy[W-1:0];
      end
      if (cmd.mul) begin
         div_ff <= (2*W)'(mag_ff) * (2*W)'(t_ff);
      end else if (cmd.div_step) begin
         div_ff <= {(take ? (trial[W-1:0] - dx_ff) : trial[W-1:0]), div_ff[W-2:0], take};
      end
      if (cmd.load_rsp) begin
         in_range_ff   <= found_ff;
         zero_width_ff <= found_ff && zw_ff;
         if (!found_ff) begin
            value_ff     <= '0;
            saturated_ff <= 1'b0;
         end else if (zw_ff) begin
            value_ff     <= lo_y_ff;
            saturated_ff <= 1'b0;
         end else begin
            value_ff     <= sum_value;
            saturated_ff <= sum_sat;
         end
      end
   end

   assign value      = value_ff;
   assign in_range   = in_range_ff;
   assign zero_width = zero_width_ff;
   assign saturated  = saturated_ff;

endmodule

// ----- src/pwl_ctrl.sv -----
// controller: handshakes, point count register, segment scan and divide sequencing
// depends on pwl_pkg
module pwl_ctrl #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_mode,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_tvalid,
   output logic                               csr_tready,
   input  logic [pwl_pkg::COUNT_W-1:0]        csr_count,
   input  pwl_pkg::status_type                status,
   output pwl_pkg::cmd_type                   cmd,
   output logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LOAD,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [pwl_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]               n_eff;
   logic                        accept;

   assign n_eff = (32'(count_ff) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rd_addr    = idx_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      count_in     = (csr_tvalid && csr_tready) ? csr_count : count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == pwl_pkg::MODE_WRITE) begin
                  cmd.write_point = 1'b1;
               end else begin
                  cmd.load_query = 1'b1;
                  idx_in         = '0;
                  state_in       = (n_eff < CW'(2)) ? ST_OUT : ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            cmd.rd_en = 1'b1;
            idx_in    = idx_ff + CW'(1);
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_low = 1'b1;
            cmd.rd_en    = 1'b1;
            idx_in       = idx_ff + CW'(1);
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.seg_match) begin
               cmd.prep = 1'b1;
               state_in = status.seg_zero_width ? ST_OUT : ST_MUL;
            end else if (idx_ff == n_eff) begin
               state_in = ST_OUT;
            end else begin
               cmd.load_low = 1'b1;
               cmd.rd_en    = 1'b1;
               idx_in       = idx_ff + CW'(1);
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         count_ff     <= pwl_pkg::COUNT_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- tb/sv/piecewise_linear_interpolator_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the piecewise linear interpolator: breakpoint loads, queries,
// point_count changes and random stalls on both streams, checked against an in-bench predictor
// depends on pwl_pkg and piecewise_linear_interpolator
module piecewise_linear_interpolator_tb;

   localparam int TABLE_DEPTH = 64;
   localparam int RANDOM_ITEMS = 700;
   localparam int SCAN_DRAIN_CYCLES = 120;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [31:0] value;
      logic        in_range;
      logic        zero_width;
      logic        saturated;
   } interp_result_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [103:0]  req_tdata;  // point_index, point_x, point_y, query_x, zero pad
   logic          req_tuser;  // mode
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [31:0]   rsp_tdata;  // value
   logic [2:0]    rsp_tuser;  // in_range, zero_width, saturated
   logic          csr_tvalid;
   logic          csr_tready;
   logic [7:0]    csr_tdata;  // point_count, zero pad

   // predictor state
   logic signed [31:0] knot_x [TABLE_DEPTH];
   logic signed [31:0] knot_y [TABLE_DEPTH];
   logic [6:0]         knot_count = 7'd2;

   interp_result_type expected_results[$];
   interp_result_type want;
   int             mismatches = 0;
   int             items_sent = 0;
   int             rsp_hold_cycles = 0;
   bit             steady = 1'b0;
   int unsigned    cycle_count = 0;

   piecewise_linear_interpolator #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic interp_result_type interpolate(input logic signed [31:0] query);
      interp_result_type r;
      int used, i;
      longint q, x0, x1, y0, y1, dy, sum;
      longint unsigned mag, t, dx, quo;
      r = '0;
      q = query;
      used = (knot_count > TABLE_DEPTH) ? TABLE_DEPTH : knot_count;
      for (i = 0; i + 1 < used && !r.in_range; i++) begin
         x0 = knot_x[i];
         x1 = knot_x[i + 1];
         if (q >= x0 && q <= x1) begin
            r.in_range = 1'b1;
            y0 = knot_y[i];
            y1 = knot_y[i + 1];
            if (x0 == x1) begin
               r.zero_width = 1'b1;
               r.value = y0[31:0];
            end else begin
               dy = y1 - y0;
               mag = (dy < 0) ? -dy : dy;
               t = q - x0;
               dx = x1 - x0;
               quo = (mag * t) / dx;
               sum = (dy < 0) ? y0 - signed'(quo) : y0 + signed'(quo);
               if (sum > VALUE_MAX) begin
                  sum = VALUE_MAX;
                  r.saturated = 1'b1;
               end else if (sum < VALUE_MIN) begin
                  sum = VALUE_MIN;
                  r.saturated = 1'b1;
               end
               r.value = sum[31:0];
            end
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // often inside the loaded span, some on breakpoints, just outside, or anywhere
   function automatic logic [31:0] pick_query(input int slots);
      longint a, b, v;
      v = $signed($urandom());
      if (slots >= 2) begin
         a = knot_x[0];
         b = knot_x[slots - 1];
         case ($urandom_range(0, 9))
            0, 1, 2, 3: if (a <= b) v = a + $urandom_range(0, 32'(b - a));
            4, 5: v = knot_x[$urandom_range(0, slots - 1)];
            6: v = (a > VALUE_MIN) ? a - 1 : a;
            7: v = (b < VALUE_MAX) ? b + 1 : b;
            default: ;
         endcase
      end
      return v[31:0];
   endfunction

   task automatic send_item(input logic mode, input logic [5:0] slot, input logic [31:0] px,
                            input logic [31:0] py, input logic [31:0] qx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {2'b00, qx, py, px, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (mode == pwl_pkg::MODE_WRITE) begin
         knot_x[slot] = px;
         knot_y[slot] = py;
      end else begin
         expected_results.push_back(interpolate(qx));
      end
   endtask

   task automatic send_point(input logic [5:0] slot, input logic [31:0] px,
                             input logic [31:0] py);
      send_item(pwl_pkg::MODE_WRITE, slot, px, py, $urandom());
   endtask

   task automatic send_query(input logic [31:0] qx);
      send_item(pwl_pkg::MODE_QUERY, 6'($urandom()), $urandom(), $urandom(), qx);
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic wait_idle();
      wait_results();
      repeat (SCAN_DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_point_count(input logic [6:0] count);
      wait_idle();
      csr_tvalid <= 1'b1;
      csr_tdata <= {1'b0, count};
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
      knot_count = count;
   endtask

   // ascending abscissae with random steps, a few stray ones out of order
   task automatic load_table(input int slots);
      longint lo, hi, x, step_max, tmp;
      int i;
      lo = $signed($urandom());
      hi = $signed($urandom());
      if (lo > hi) begin
         tmp = lo;
         lo = hi;
         hi = tmp;
      end
      case ($urandom_range(0, 4))
         0: begin
            lo = VALUE_MIN;
            hi = VALUE_MAX;
         end
         1: begin
            hi = lo + $urandom_range(0, 4 * slots);
            if (hi > VALUE_MAX) hi = VALUE_MAX;
         end
         default: ;
      endcase
      step_max = (slots > 1) ? (hi - lo) / (slots - 1) : 0;
      x = lo;
      for (i = 0; i < slots; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_point(6'(i), $urandom(), $urandom());
         else
            send_point(6'(i), x[31:0], $urandom());
         x = x + $urandom_range(0, 32'(step_max));
      end
   endtask

   task automatic test_directed();
      // zero-width first segment, full-swing falling and rising segments, then a backward pair
      send_point(6'd0, 32'h8000_0000, 32'h0005_0000);
      send_point(6'd1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(6'd2, 32'h0000_0000, 32'h8000_0000);
      send_point(6'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(6'd4, 32'h0000_1000, 32'h1234_5678);
      send_point(6'd5, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      // count still at its reset value
      send_query(32'h8000_0000);
      send_query(32'h0000_0000);
      send_query(32'h7FFF_FFFF);
      set_point_count(7'd0);
      send_query(32'h0000_0000);
      set_point_count(7'd1);
      send_query(32'h8000_0000);
      set_point_count(7'd4);
      send_query(32'h8000_0001);
      send_query(32'hFFFF_FFFF);
      send_query(32'h0000_0000);
      send_query(32'h0001_8000);
      send_query(32'h7FFF_FFFF);
      set_point_count(7'd6);
      send_query(32'h0000_1000);
      send_query(32'h7FFF_FFFE);
   endtask

   task automatic test_receiver_hold();
      int k;
      set_point_count(7'd4);
      rsp_hold_cycles = 600;
      for (k = 0; k < 8; k++)
         send_query(pick_query(4));
   endtask

   task automatic test_sender_pause();
      int k;
      for (k = 0; k < 6; k++)
         send_query(pick_query(4));
      wait_results();
      for (k = 0; k < 6; k++)
         send_query(pick_query(4));
   endtask

   task automatic test_random();
      int start, n, slots, k, burst;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0: n = 0;
            1: n = 1;
            2: n = TABLE_DEPTH;
            3: n = 127;
            4: n = $urandom_range(TABLE_DEPTH + 1, 126);
            default: n = $urandom_range(2, 12);
         endcase
         set_point_count(7'(n));
         steady = ($urandom_range(0, 3) == 0);
         slots = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
         load_table(slots);
         burst = $urandom_range(10, 40);
         for (k = 0; k < burst; k++) begin
            if ($urandom_range(0, 6) == 0)
               send_point(6'($urandom_range(0, TABLE_DEPTH - 1)), $urandom(), $urandom());
            else
               send_query(pick_query(slots));
         end
      end
      steady = 1'b0;
   endtask

   // result side: random stalls, plus a long hold-off when asked
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer: value %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("value: expected %h, got %h", want.value, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser[0] !== want.in_range) begin
               $error("in_range: expected %b, got %b", want.in_range, rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tuser[1] !== want.zero_width) begin
               $error("zero_width: expected %b, got %b", want.zero_width, rsp_tuser[1]);
               mismatches++;
            end
            if (rsp_tuser[2] !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, rsp_tuser[2]);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= pwl_pkg::MODE_WRITE;
      csr_tvalid <= 1'b0;
      csr_tdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_receiver_hold();
      test_sender_pause();
      test_random();
      wait_idle();
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/pwl_pkg.sv
src/pwl_ram.sv
src/pwl_datapath.sv
src/pwl_ctrl.sv
src/piecewise_linear_interpolator.sv
tb/sv/piecewise_linear_interpolator_tb.sv
